@@ hdl/rqc_pkg.sv @@
// Shared types and constants of the resource quota counter block.
package rqc_pkg;

  localparam int unsigned CntW     = 64;
  localparam int unsigned NumCaps  = 8;
  localparam int unsigned CapIdxW  = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned KindW    = 3;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [CmdW-1:0] {
    CmdConsume = 2'd0,
    CmdRelease = 2'd1,
    CmdQuery   = 2'd2
  } command_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StCap      = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [KindW-1:0] kind;
    logic [CntW-1:0]  amount;
  } rqc_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CntW-1:0]    usage;
    logic [CntW-1:0]    headroom;
  } rqc_out_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [CntW-1:0]    data;
  } rqc_cfg_t;

endpackage

@@ hdl/rqc_cap_regs.sv @@
// Register file holding the per-kind usage caps written over the configuration channel.
module rqc_cap_regs import rqc_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rqc_cfg_t                        cfg_i,
  output logic                            ready_o,
  output logic [NumCaps-1:0][CntW-1:0]    caps_o
);

  logic [NumCaps-1:0][CntW-1:0] caps_q;

  // Writes are always taken; an index beyond the last cap is dropped.
  assign ready_o = 1'b1;
  assign caps_o  = caps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q <= '0;
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxW'(NumCaps))) begin
      caps_q[cfg_i.index[CapIdxW-1:0]] <= cfg_i.data;
    end
  end

endmodule

@@ hdl/rqc_update.sv @@
// Combinational counter update, status and headroom for one command.
module rqc_update import rqc_pkg::*; (
  input  logic [CmdW-1:0] command_i,
  input  logic [CntW-1:0] amount_i,
  input  logic [CntW-1:0] use_i,
  input  logic [CntW-1:0] cap_i,
  output rqc_out_t        result_o
);

  logic [CntW:0]      sum;
  logic [CntW-1:0]    use_new;
  logic [StatusW-1:0] status;

  assign sum = {1'b0, use_i} + {1'b0, amount_i};

  always_comb begin
    use_new = use_i;
    status  = StOk;
    case (command_i)
      CmdConsume: begin
        if (sum[CntW]) begin
          status = StOverflow;
        end else if ((cap_i != '0) && (sum[CntW-1:0] > cap_i)) begin
          status = StCap;
        end else begin
          use_new = sum[CntW-1:0];
        end
      end
      CmdRelease: begin
        use_new = (amount_i > use_i) ? '0 : use_i - amount_i;
      end
      default: begin
        use_new = use_i;
      end
    endcase
  end

  always_comb begin
    result_o.status = status;
    result_o.usage  = use_new;
    if (cap_i == '0) begin
      result_o.headroom = '1;
    end else if (use_new >= cap_i) begin
      result_o.headroom = '0;
    end else begin
      result_o.headroom = cap_i - use_new;
    end
  end

endmodule

@@ hdl/resource_quota_counters.sv @@
// Top level of the resource quota counter table.
//
// The block keeps one 64-bit usage counter per resource kind, each checked
// against a cap written over the configuration channel (a cap of zero means
// unlimited). A command transfer happens at a rising edge with start_i high
// and busy_o low; item_i carries the command, the kind and the amount.
// Consume adds the amount unless the sum overflows or passes a nonzero cap,
// release subtracts it and saturates at zero, and query changes nothing.
//
// Each command yields exactly one result on result_o, marked by a one-cycle
// result_valid_o strobe that starts in the cycle after the command's input
// register is loaded and comes from the result register. One command is
// taken every cycle while busy_o is low; the counter written by one command
// is read by the next one from the counter registers, so back-to-back
// commands on the same kind see each other.
//
// The receiver cannot stall, so there is no backpressure on the result side.
// Reset clears all counters and caps; busy_o is high while reset is held and
// drops at the first edge after release. Cap writes are taken on every cycle
// the configuration channel is valid and are meant to arrive while idle.
module resource_quota_counters import rqc_pkg::*; #(
  parameter int unsigned NUM_KINDS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  rqc_in_t            item_i,
  output logic               result_valid_o,
  output rqc_out_t           result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i
);

  localparam int unsigned KindIdxW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

  rqc_cfg_t                     cfg;
  logic [NumCaps-1:0][CntW-1:0] caps;
  logic                         busy_q;
  logic                         in_valid_q;
  rqc_in_t                      in_q;
  logic [NUM_KINDS-1:0][CntW-1:0] cnt_q;
  logic                         kind_ok;
  logic [CntW-1:0]              use_cur;
  logic [CntW-1:0]              cap_cur;
  rqc_out_t                     upd;
  rqc_out_t                     out_d;
  rqc_out_t                     out_q;
  logic                         out_valid_q;

  assign cfg.valid = cfg_valid_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  rqc_cap_regs u_cap_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .ready_o (cfg_ready_o),
    .caps_o  (caps)
  );

  // Commands are held off only while coming out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  // Input register: the command transfer lands here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      in_q <= item_i;
    end
  end

  // A kind with no counter behind it is answered but changes nothing.
  assign kind_ok = {1'b0, in_q.kind} < (KindW + 1)'(NUM_KINDS);
  assign use_cur = kind_ok ? cnt_q[in_q.kind[KindIdxW-1:0]] : '0;
  assign cap_cur = caps[in_q.kind];

  rqc_update u_update (
    .command_i (in_q.command),
    .amount_i  (in_q.amount),
    .use_i     (use_cur),
    .cap_i     (cap_cur),
    .result_o  (upd)
  );

  always_comb begin
    if (kind_ok) begin
      out_d = upd;
    end else begin
      out_d.status   = StOk;
      out_d.usage    = '0;
      out_d.headroom = '1;
    end
  end

  // Counter table; the updated value is written back in the same edge that
  // loads the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_valid_q && kind_ok) begin
      cnt_q[in_q.kind[KindIdxW-1:0]] <= upd.usage;
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // Every command transfer is followed by its result strobe, through the input and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 result_valid_o)
    else $error("command transfer without a matching result strobe");

  // A query never modifies any counter.
  a_query_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (in_q.command == CmdQuery)) |=> $stable(cnt_q))
    else $error("query changed the counter table");

  // Only a consume can report an error status.
  a_err_only_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != StOk)) |->
      ($past(in_q.command) == CmdConsume))
    else $error("error status on a command other than consume");

  // A rejected consume leaves the counter table untouched.
  a_err_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (out_d.status != StOk)) |=> $stable(cnt_q))
    else $error("rejected consume modified a counter");

endmodule

@@ sim/resource_quota_counters_tb.sv @@
// Self-checking testbench for the resource quota counter table, with its own usage and cap model.
module resource_quota_counters_tb;
  import rqc_pkg::*;

  localparam int unsigned NumKinds = 8;

  // Code 3 is not a defined command; the block must treat it like a query.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  rqc_in_t            item_i = '0;
  logic               result_valid_o;
  rqc_out_t           result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CntW-1:0]    cfg_data_i = '0;

  resource_quota_counters #(
    .NUM_KINDS(NumKinds)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the block's state: the caps as last written over the
  // configuration channel and one usage level per kind.
  logic [CntW-1:0] cap_model [NumCaps] = '{default: '0};
  logic [CntW-1:0] level_model [NumKinds] = '{default: '0};

  rqc_in_t  commands_to_send [$];
  rqc_out_t answers_due [$];
  int unsigned commands_queued = 0;
  int unsigned commands_taken = 0;
  int unsigned mismatches = 0;

  // Sender pacing: bursts of back-to-back commands, most separated by idle gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  // Applies one command to the shadow state and returns the answer that the
  // block owes for it. A consume checks 64-bit overflow before the cap, so a
  // sum that both wraps and passes the cap reports overflow.
  function automatic rqc_out_t account_command(rqc_in_t cmd);
    rqc_out_t        ans;
    logic [CntW:0]   total;
    logic [CntW-1:0] level;
    logic [CntW-1:0] cap;
    ans.status   = StOk;
    ans.usage    = '0;
    ans.headroom = '1;
    if (cmd.kind >= NumKinds || cmd.kind >= NumCaps) return ans;
    level = level_model[cmd.kind];
    cap   = cap_model[cmd.kind];
    total = {1'b0, level} + {1'b0, cmd.amount};
    case (cmd.command)
      CmdConsume: begin
        if (total[CntW]) ans.status = StOverflow;
        else if (cap != '0 && total[CntW-1:0] > cap) ans.status = StCap;
        else level = total[CntW-1:0];
      end
      CmdRelease: begin
        level = (cmd.amount > level) ? '0 : level - cmd.amount;
      end
      default: ;
    endcase
    level_model[cmd.kind] = level;
    ans.usage    = level;
    // An unlimited cap reads as full headroom; a cap at or below the level
    // (for instance after the cap was lowered) reads as none.
    ans.headroom = (cap == '0) ? '1 : (level >= cap) ? '0 : cap - level;
    return ans;
  endfunction

  task automatic note_mismatch(input string what, input logic [CntW-1:0] got,
                               input logic [CntW-1:0] want);
    $display("mismatch in %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  function automatic void send(input logic [CmdW-1:0] cmd, input logic [KindW-1:0] kind,
                               input logic [CntW-1:0] amount);
    rqc_in_t c;
    c.command = cmd;
    c.kind    = kind;
    c.amount  = amount;
    commands_to_send.push_back(c);
    commands_queued++;
  endfunction

  // Amounts lean toward small values so that small caps are hit often, with
  // all-ones, full random and half-range values to provoke overflow.
  function automatic logic [CntW-1:0] draw_amount();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CntW'($urandom_range(0, 300));
      4:          return '1;
      5, 6:       return {$urandom, $urandom};
      7:          return 64'h8000_0000_0000_0000 - CntW'($urandom_range(0, 3));
      default:    return CntW'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [CntW-1:0] draw_cap();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CntW'($urandom_range(1, 1500));
      2:       return '1;
      3:       return {$urandom, $urandom};
      4:       return 64'h8000_0000_0000_0000;
      default: return CntW'(1);
    endcase
  endfunction

  function automatic rqc_in_t draw_command();
    rqc_in_t     c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 9) c.command = CmdConsume;
    else if (pick < 13) c.command = CmdRelease;
    else if (pick < 18) c.command = CmdQuery;
    else c.command = CmdUnused;
    c.kind   = KindW'($urandom_range(0, NumKinds - 1));
    c.amount = draw_amount();
    return c;
  endfunction

  // One cap write over the configuration channel. The shadow cap changes at
  // the edge that completes the transfer; indexes past the last cap are
  // expected to be dropped by the block.
  task automatic write_cap(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumCaps) cap_model[idx[CapIdxW-1:0]] = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued command has been taken and answered, then lets
  // the clock run on before it returns.
  task automatic wait_idle();
    while (commands_taken != commands_queued || answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver. A command transfer completes at an edge where start_i is high
  // and busy_o is low; the expected answer is worked out right there, so the
  // shadow state moves in the same order as the block's counters. A command
  // that is still waiting on busy_o is held unchanged.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      item_i  <= '0;
    end else begin
      if (start_i && !busy_o) begin
        answers_due.push_back(account_command(item_i));
        commands_taken++;
      end
      if (start_i && busy_o) begin
        // Hold the current command until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (commands_to_send.size() != 0) begin
        item_i  <= commands_to_send.pop_front();
        start_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Roughly four bursts in ten run straight into the next one.
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor. Every strobed result is a transfer, since the receiver cannot
  // stall, and is matched against the oldest outstanding answer.
  always @(posedge clk_i) begin
    rqc_out_t want;
    if (rst_ni && result_valid_o) begin
      if (answers_due.size() == 0) begin
        note_mismatch("result with nothing outstanding", result_o.usage, '0);
      end else begin
        want = answers_due.pop_front();
        if (result_o.status !== want.status)
          note_mismatch("status", CntW'(result_o.status), CntW'(want.status));
        if (result_o.usage !== want.usage)
          note_mismatch("usage", result_o.usage, want.usage);
        if (result_o.headroom !== want.headroom)
          note_mismatch("headroom", result_o.headroom, want.headroom);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Caps for the directed part: a mid-size cap, unlimited, all ones, a cap
    // of one, and a small cap for the overflow-versus-cap case. The write to
    // index 8 must not alias onto kind 0.
    write_cap(CfgIdxW'(0), 64'd100);
    write_cap(CfgIdxW'(1), '0);
    write_cap(CfgIdxW'(2), '1);
    write_cap(CfgIdxW'(3), 64'd1);
    write_cap(CfgIdxW'(4), '0);
    write_cap(CfgIdxW'(5), 64'd10);
    write_cap(CfgIdxW'(6), 64'd1500);
    write_cap(CfgIdxW'(7), '0);
    write_cap(CfgIdxW'(NumCaps), 64'd5);

    send(CmdConsume, 3'd0, 64'd60);
    send(CmdConsume, 3'd0, 64'd41);   // one past the cap
    send(CmdConsume, 3'd0, 64'd40);   // lands exactly on the cap
    send(CmdQuery,   3'd0, '1);
    send(CmdRelease, 3'd0, 64'd30);
    send(CmdRelease, 3'd0, '1);       // release past zero saturates
    send(CmdConsume, 3'd1, '1);       // unlimited kind filled to the top
    send(CmdConsume, 3'd1, 64'd1);    // wraps 64 bits
    send(CmdUnused,  3'd1, {$urandom, $urandom});
    send(CmdConsume, 3'd2, '1);       // reaches an all-ones cap
    send(CmdConsume, 3'd3, '0);
    send(CmdConsume, 3'd3, 64'd1);
    send(CmdConsume, 3'd3, 64'd1);
    send(CmdConsume, 3'd5, 64'd5);
    send(CmdConsume, 3'd5, '1);       // both wraps and passes the cap
    send(CmdRelease, 3'd7, 64'd7);
    send(CmdConsume, 3'd6, '0);
    wait_idle();

    // Lower the cap of kind 1 far below its usage: even a zero consume must
    // now fail on the cap, and headroom reads zero until a release.
    write_cap(CfgIdxW'(1), 64'd5);
    send(CmdConsume, 3'd1, '0);
    send(CmdQuery,   3'd1, '0);
    send(CmdRelease, 3'd1, '1);
    send(CmdConsume, 3'd1, 64'd5);

    // Random phases. The first runs with every kind unlimited and the last
    // with every cap at all ones; the ones between mix cap styles. Each
    // phase also writes a random index past the last cap.
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      for (int idx = 0; idx < NumCaps; idx++) begin
        if (phase == 0) write_cap(CfgIdxW'(idx), '0);
        else if (phase == 4) write_cap(CfgIdxW'(idx), '1);
        else write_cap(CfgIdxW'(idx), draw_cap());
      end
      write_cap(CfgIdxW'(NumCaps + $urandom_range(0, 7)), {$urandom, $urandom});
      for (int n = 0; n < 130; n++) begin
        commands_to_send.push_back(draw_command());
        commands_queued++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout set far beyond the slowest correct run.
  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

endmodule
